/* src/board_power_sequencer_top_defines.svh */
// assertion macros used by the checker file
`ifndef BOARD_POWER_SEQUENCER_TOP_DEFINES_SVH
`define BOARD_POWER_SEQUENCER_TOP_DEFINES_SVH

// concurrent check, masked while reset is high
`define BPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("board power sequencer check failed");

// concurrent check that also runs during reset
`define BPS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("board power sequencer check failed");

`endif

/* src/bps_pkg.sv */
// package with payload types, codes and constants of the board power sequencer
package bps_pkg;

   localparam int PowerupTries = 3;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int MaskWidth    = 8;

   typedef enum logic [2:0] {
      PM_INIT    = 3'd0,
      PM_OFF_NPG = 3'd1,
      PM_OFF_PG  = 3'd2,
      PM_POWERUP = 3'd3,
      PM_CHECK   = 3'd4,
      PM_ON      = 3'd5,
      PM_DOWN    = 3'd6,
      PM_CYCLE   = 3'd7
   } power_mode_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_EVENT = 2'd1,
      REQ_CYCLE = 2'd2,
      REQ_DOWN  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_OFF    = 2'd1,
      ACT_ON_SEQ = 2'd2
   } rail_action_type;

   typedef enum logic [2:0] {
      NT_NONE   = 3'd0,
      NT_ON     = 3'd1,
      NT_OFF    = 3'd2,
      NT_OFF_PG = 3'd3,
      NT_OFF_PB = 3'd4,
      NT_REBOOT = 3'd5
   } notify_type;

   localparam logic [CsrAddrWidth-3:0] RegStartEnableMask = 1'b0;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] reason;
      logic       rail_ok;
      logic       ext_pgood;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] state_code;
      logic [7:0] start_reason;
      logic       is_on;
      logic       is_off;
      logic       pgood_filtered;
      logic [1:0] rail_action;
      logic [2:0] notify;
   } rsp_payload_type;

endpackage

/* src/board_power_sequencer_top.sv */
// top level of the board power sequencer
//
//   port group  direction  handshake        contents
//   req_        in         valid / ready    request type, reason mask, rail_ok, ext_pgood
//   rsp_        out        valid / ready    state, start reason, flags, rail action, notify
//   csr_        in / out   apb, pready = 1  start_enable_mask at byte address 0
//
// a request is held in the input register, then one step of the state machine moves
// it into the result register once that register is free or being emptied; a
// stalled result keeps the request waiting in the input register
// throughput is one request per cycle while the result is not stalled
// reset is synchronous and active high: init state, retry count and reason cleared
// a stalled result holds; the input register still takes one more request behind it
module board_power_sequencer_top #(
   parameter int POWERUP_TRIES = bps_pkg::PowerupTries
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bps_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bps_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bps_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [bps_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [bps_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   // input register
   logic                     in_valid_ff, in_valid_in;
   bps_pkg::req_payload_type in_data_ff, in_data_in;
   // result register
   logic                     out_valid_ff, out_valid_in;
   bps_pkg::rsp_payload_type out_data_ff, out_data_in;

   logic                          step_en;
   logic                          req_take;
   logic [bps_pkg::MaskWidth-1:0] start_enable_mask;
   bps_pkg::rsp_payload_type      step_rsp;

   // a request steps when the result register is free or being emptied
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   bps_csr u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .start_enable_mask (start_enable_mask)
   );

   // state lives here; apart from reset it only changes on a step
   bps_core #(
      .POWERUP_TRIES (POWERUP_TRIES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .step_en           (step_en),
      .req               (in_data_ff),
      .start_enable_mask (start_enable_mask),
      .rsp               (step_rsp)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step_en) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end
      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (step_en) begin
         out_valid_in = 1'b1;
         out_data_in  = step_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

/* src/bps_csr.sv */
// configuration register file with the start-enable mask
module bps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bps_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [bps_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [bps_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready,
   output logic [bps_pkg::MaskWidth-1:0]      start_enable_mask
);

   logic [bps_pkg::MaskWidth-1:0] mask_ff;
   logic [bps_pkg::MaskWidth-1:0] mask_in;
   logic                          hit;
   logic                          wr_en;

   // word index is the address above the byte offset
   assign hit   = (csr_paddr[bps_pkg::CsrAddrWidth-1:2] == bps_pkg::RegStartEnableMask);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && hit;

   always_comb begin
      mask_in = mask_ff;
      if (wr_en) begin
         mask_in = csr_pwdata[bps_pkg::MaskWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   assign csr_pready        = 1'b1;
   assign csr_prdata        = hit ? {{(bps_pkg::CsrDataWidth-bps_pkg::MaskWidth){1'b0}}, mask_ff}
                                  : '0;
   assign start_enable_mask = mask_ff;

endmodule

/* src/bps_core.sv */
// sequencer state registers and the one-step transition logic
module bps_core #(
   parameter int POWERUP_TRIES = bps_pkg::PowerupTries
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  bps_pkg::req_payload_type      req,
   input  logic [bps_pkg::MaskWidth-1:0] start_enable_mask,
   output bps_pkg::rsp_payload_type      rsp
);

   localparam int RetryWidth = $clog2(POWERUP_TRIES + 1);

   bps_pkg::power_mode_type mode_ff, mode_in;
   logic [RetryWidth-1:0]   retries_ff, retries_in;
   logic [7:0]              reason_ff, reason_in;
   bps_pkg::rail_action_type act;
   bps_pkg::notify_type      nt;
   logic                     accepted;
   logic                     is_off_pre;
   logic                     on, off;

   assign accepted   = |(start_enable_mask & req.reason);
   assign is_off_pre = (mode_ff == bps_pkg::PM_OFF_NPG) || (mode_ff == bps_pkg::PM_OFF_PG);

   always_comb begin
      mode_in    = mode_ff;
      retries_in = retries_ff;
      reason_in  = reason_ff;
      act        = bps_pkg::ACT_NONE;
      nt         = bps_pkg::NT_NONE;
      case (bps_pkg::req_kind_type'(req.req_type))
         bps_pkg::REQ_TICK: begin
            case (mode_ff)
               bps_pkg::PM_INIT: begin
                  if (req.rail_ok) begin
                     mode_in = bps_pkg::PM_ON;
                     nt      = bps_pkg::NT_ON;
                  end else begin
                     mode_in    = bps_pkg::PM_POWERUP;
                     retries_in = RetryWidth'(POWERUP_TRIES);
                  end
               end
               bps_pkg::PM_DOWN: begin
                  act       = bps_pkg::ACT_OFF;
                  nt        = bps_pkg::NT_OFF;
                  reason_in = '0;
                  mode_in   = req.ext_pgood ? bps_pkg::PM_OFF_PG : bps_pkg::PM_OFF_NPG;
               end
               bps_pkg::PM_OFF_NPG: begin
                  if (req.ext_pgood) begin
                     mode_in = bps_pkg::PM_OFF_PG;
                     nt      = bps_pkg::NT_OFF_PG;
                  end
               end
               bps_pkg::PM_OFF_PG: begin
                  if (!req.ext_pgood) begin
                     mode_in = bps_pkg::PM_OFF_NPG;
                     nt      = bps_pkg::NT_OFF_PB;
                  end
               end
               bps_pkg::PM_POWERUP: begin
                  if (retries_ff != '0) begin
                     retries_in = retries_ff - RetryWidth'(1);
                  end
                  mode_in = bps_pkg::PM_CHECK;
                  act     = bps_pkg::ACT_ON_SEQ;
               end
               bps_pkg::PM_CHECK: begin
                  if (req.rail_ok) begin
                     mode_in = bps_pkg::PM_ON;
                     nt      = bps_pkg::NT_ON;
                  end else if (retries_ff != '0) begin
                     act     = bps_pkg::ACT_OFF;
                     mode_in = bps_pkg::PM_POWERUP;
                  end else begin
                     mode_in = bps_pkg::PM_DOWN;
                  end
               end
               bps_pkg::PM_ON: begin
                  if (!req.rail_ok) begin
                     mode_in = bps_pkg::PM_DOWN;
                  end
               end
               default: begin
                  // cycle: rails off, then a fresh power-up
                  act        = bps_pkg::ACT_OFF;
                  nt         = bps_pkg::NT_REBOOT;
                  mode_in    = bps_pkg::PM_POWERUP;
                  retries_in = RetryWidth'(POWERUP_TRIES);
               end
            endcase
         end
         bps_pkg::REQ_EVENT: begin
            if (is_off_pre && accepted) begin
               reason_in  = req.reason;
               mode_in    = bps_pkg::PM_POWERUP;
               retries_in = RetryWidth'(POWERUP_TRIES);
            end
         end
         bps_pkg::REQ_CYCLE: begin
            if (accepted) begin
               reason_in = req.reason;
               mode_in   = bps_pkg::PM_CYCLE;
            end
         end
         default: begin
            if (mode_ff == bps_pkg::PM_ON) begin
               mode_in = bps_pkg::PM_DOWN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= bps_pkg::PM_INIT;
         retries_ff <= '0;
         reason_ff  <= '0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         retries_ff <= retries_in;
         reason_ff  <= reason_in;
      end
   end

   assign on  = (mode_in == bps_pkg::PM_ON);
   assign off = (mode_in == bps_pkg::PM_OFF_NPG) || (mode_in == bps_pkg::PM_OFF_PG);

   always_comb begin
      rsp.state_code     = mode_in;
      rsp.start_reason   = reason_in;
      rsp.is_on          = on;
      rsp.is_off         = off;
      rsp.pgood_filtered = req.ext_pgood && (on || (mode_in == bps_pkg::PM_OFF_PG));
      rsp.rail_action    = act;
      rsp.notify         = nt;
   end

endmodule

/* src/bps_checker.sv */
// port-level checks of the board power sequencer, bound to the top level
`include "board_power_sequencer_top_defines.svh"

module bps_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input bps_pkg::rsp_payload_type rsp_payload
);

   logic st_on;
   logic st_off_npg;
   logic st_off_pg;

   assign st_on      = (rsp_payload.state_code == bps_pkg::PM_ON);
   assign st_off_npg = (rsp_payload.state_code == bps_pkg::PM_OFF_NPG);
   assign st_off_pg  = (rsp_payload.state_code == bps_pkg::PM_OFF_PG);

   // a stalled result holds
   `BPS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // nothing comes out right after a reset edge
   `BPS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // on flag agrees with the state
   `BPS_ASSERT(a_on_flag, clock, reset, rsp_valid |-> rsp_payload.is_on == st_on)

   // off flag agrees with the state
   `BPS_ASSERT(a_off_flag, clock, reset, rsp_valid |-> rsp_payload.is_off == (st_off_npg || st_off_pg))

   // filtered power-good only in on or off-with-pgood
   `BPS_ASSERT(a_pgood_filt, clock, reset, rsp_valid && rsp_payload.pgood_filtered |-> st_on || st_off_pg)

endmodule

bind board_power_sequencer_top bps_checker u_bps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

/* dv/tb_board_power_sequencer_top.sv */
// testbench for the board power sequencer: directed and random requests checked against a predictor
module tb_board_power_sequencer_top;

   localparam int ClockPeriod   = 10;
   localparam int ResetCycles   = 10;
   localparam int DrainCycles   = 4;     // margin after the last result is back
   localparam int LongHold      = 80;    // receiver hold-off that fills the block
   localparam int WatchdogLimit = 2000;  // cycles with no accept on either channel
   localparam logic [bps_pkg::CsrAddrWidth-1:0] MaskAddr = {bps_pkg::RegStartEnableMask, 2'b00};

   // dut inputs, all known from time zero
   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   bps_pkg::req_payload_type         req_payload = '0;
   logic                             rsp_ready   = 1'b0;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [bps_pkg::CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [bps_pkg::CsrDataWidth-1:0] csr_pwdata  = '0;

   // dut outputs
   logic                             req_ready;
   logic                             rsp_valid;
   bps_pkg::rsp_payload_type         rsp_payload;
   logic [bps_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   // requests waiting to be offered, and results predicted for accepted requests
   bps_pkg::req_payload_type         pending_reqs[$];
   bps_pkg::rsp_payload_type         expected_rsps[$];

   // knobs set by the stimulus, read by the driver and the ready process
   int                      send_idle_pct = 0;
   int                      rsp_stall_pct = 0;
   logic                    hold_armed    = 1'b0;  // toggled to ask for a long hold-off
   logic                    hold_seen     = 1'b0;
   int                      hold_left     = 0;

   logic                    req_taken     = 1'b0;  // request accepted at the last rising edge
   int                      quiet_cycles  = 0;
   int                      mismatches    = 0;

   // shadow of the sequencer: mode, retry count, stored start reason, enable mask
   bps_pkg::power_mode_type seq_mode   = bps_pkg::PM_INIT;
   logic [3:0]              seq_tries  = '0;
   logic [7:0]              seq_reason = '0;
   logic [7:0]              seq_mask   = '0;

   board_power_sequencer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // enter power-up with a full retry budget
   function automatic void start_powerup();
      seq_tries = 4'(bps_pkg::PowerupTries);
      seq_mode  = bps_pkg::PM_POWERUP;
   endfunction

   // one step of the sequencer for an accepted request, returns the result it shows
   function automatic bps_pkg::rsp_payload_type advance_sequencer(
      bps_pkg::req_payload_type rq);
      bps_pkg::rsp_payload_type res;
      bps_pkg::rail_action_type act;
      bps_pkg::notify_type      nt;
      logic            rail;
      logic            pg;
      logic            on_now;
      act  = bps_pkg::ACT_NONE;
      nt   = bps_pkg::NT_NONE;
      rail = rq.rail_ok;
      pg   = rq.ext_pgood;
      case (bps_pkg::req_kind_type'(rq.req_type))
         bps_pkg::REQ_TICK: begin
            case (seq_mode)
               bps_pkg::PM_INIT: begin
                  if (rail) begin
                     seq_mode = bps_pkg::PM_ON;
                     nt = bps_pkg::NT_ON;
                  end else begin
                     start_powerup();
                  end
               end
               bps_pkg::PM_DOWN: begin
                  act = bps_pkg::ACT_OFF;
                  seq_mode = pg ? bps_pkg::PM_OFF_PG : bps_pkg::PM_OFF_NPG;
                  seq_reason = '0;
                  nt = bps_pkg::NT_OFF;
               end
               bps_pkg::PM_OFF_NPG: begin
                  if (pg) begin
                     seq_mode = bps_pkg::PM_OFF_PG;
                     nt = bps_pkg::NT_OFF_PG;
                  end
               end
               bps_pkg::PM_OFF_PG: begin
                  if (!pg) begin
                     seq_mode = bps_pkg::PM_OFF_NPG;
                     nt = bps_pkg::NT_OFF_PB;
                  end
               end
               bps_pkg::PM_POWERUP: begin
                  // a count already at zero stays there
                  if (seq_tries != 0) seq_tries = seq_tries - 1'b1;
                  seq_mode = bps_pkg::PM_CHECK;
                  act = bps_pkg::ACT_ON_SEQ;
               end
               bps_pkg::PM_CHECK: begin
                  if (rail) begin
                     seq_mode = bps_pkg::PM_ON;
                     nt = bps_pkg::NT_ON;
                  end else if (seq_tries != 0) begin
                     act = bps_pkg::ACT_OFF;
                     seq_mode = bps_pkg::PM_POWERUP;
                  end else begin
                     seq_mode = bps_pkg::PM_DOWN;
                  end
               end
               bps_pkg::PM_ON: begin
                  if (!rail) seq_mode = bps_pkg::PM_DOWN;
               end
               default: begin
                  act = bps_pkg::ACT_OFF;
                  nt = bps_pkg::NT_REBOOT;
                  start_powerup();
               end
            endcase
         end
         bps_pkg::REQ_EVENT: begin
            if ((seq_mode == bps_pkg::PM_OFF_NPG || seq_mode == bps_pkg::PM_OFF_PG) &&
                (rq.reason & seq_mask) != 0)
            begin
               seq_reason = rq.reason;
               start_powerup();
            end
         end
         bps_pkg::REQ_CYCLE: begin
            if ((rq.reason & seq_mask) != 0) begin
               seq_mode = bps_pkg::PM_CYCLE;
               seq_reason = rq.reason;
            end
         end
         default: begin
            if (seq_mode == bps_pkg::PM_ON) seq_mode = bps_pkg::PM_DOWN;
         end
      endcase
      on_now             = (seq_mode == bps_pkg::PM_ON);
      res.state_code     = seq_mode;
      res.start_reason   = seq_reason;
      res.is_on          = on_now;
      res.is_off         = (seq_mode == bps_pkg::PM_OFF_NPG || seq_mode == bps_pkg::PM_OFF_PG);
      res.pgood_filtered = pg && (on_now || seq_mode == bps_pkg::PM_OFF_PG);
      res.rail_action    = act;
      res.notify         = nt;
      return res;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // random request, mostly ticks, reasons mostly overlapping the current mask
   function automatic bps_pkg::req_payload_type random_request();
      bps_pkg::req_payload_type rq;
      int unsigned     pick;
      int unsigned     bit_idx;
      pick = $urandom_range(99);
      if (pick < 55)      rq.req_type = bps_pkg::REQ_TICK;
      else if (pick < 75) rq.req_type = bps_pkg::REQ_EVENT;
      else if (pick < 87) rq.req_type = bps_pkg::REQ_CYCLE;
      else                rq.req_type = bps_pkg::REQ_DOWN;
      rq.reason = 8'($urandom_range(255));
      if (seq_mask != 0 && $urandom_range(3) != 0 && (rq.reason & seq_mask) == 0) begin
         do bit_idx = $urandom_range(7); while (!seq_mask[bit_idx]);
         rq.reason[bit_idx] = 1'b1;
      end
      if ($urandom_range(15) == 0) rq.reason = '0;
      rq.rail_ok   = ($urandom_range(99) < 65);
      rq.ext_pgood = 1'($urandom_range(1));
      return rq;
   endfunction

   // driver: a request stays offered, unchanged, until it is accepted
   always @(negedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_reqs.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off counted here when asked for
   always @(negedge clock) begin : rsp_ready_driver
      if (hold_armed != hold_seen) begin
         hold_seen <= hold_armed;
         hold_left <= LongHold;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: check the result first, then predict the request accepted at this edge
   always @(posedge clock) begin : monitor
      bps_pkg::rsp_payload_type want;
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with no request pending, expected none, actual %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("state_code", want.state_code, rsp_payload.state_code);
               check_field("start_reason", want.start_reason, rsp_payload.start_reason);
               check_field("is_on", want.is_on, rsp_payload.is_on);
               check_field("is_off", want.is_off, rsp_payload.is_off);
               check_field("pgood_filtered", want.pgood_filtered, rsp_payload.pgood_filtered);
               check_field("rail_action", want.rail_action, rsp_payload.rail_action);
               check_field("notify", want.notify, rsp_payload.notify);
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(advance_sequencer(req_payload));
         req_taken = req_valid && req_ready;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles = quiet_cycles + 1;
      end
   end

   // nothing moving for too long means the block is stuck
   initial begin : watchdog
      wait (quiet_cycles >= WatchdogLimit);
      $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
      $display("Regression FAIL");
      $finish;
   end

   task automatic queue_request(bps_pkg::req_kind_type kind, logic [7:0] reason, logic rail,
                                logic pg);
      bps_pkg::req_payload_type rq;
      rq.req_type  = kind;
      rq.reason    = reason;
      rq.rail_ok   = rail;
      rq.ext_pgood = pg;
      pending_reqs.push_back(rq);
   endtask

   // wait until every queued request is accepted and every result is back
   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // apb write of the start-enable mask, then a read back of it
   task automatic set_start_mask(logic [7:0] mask);
      logic [bps_pkg::CsrDataWidth-1:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MaskAddr;
      csr_pwdata  <= bps_pkg::CsrDataWidth'(mask);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      seq_mask = mask;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== bps_pkg::CsrDataWidth'(mask)) begin
         $display("%0t: start_enable_mask read back, expected %0h, actual %0h",
                  $time, mask, rd);
         mismatches++;
      end
   endtask

   // one random phase: idle between phases, new mask, then a batch of requests
   task automatic run_phase(int idle_pct, int stall_pct, logic [7:0] mask, int count,
                            bit long_hold);
      drain();
      set_start_mask(mask);
      @(posedge clock);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (long_hold) hold_armed <= ~hold_armed;
      repeat (count) pending_reqs.push_back(random_request());
   endtask

   initial begin : stimulus
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mask still at its reset value: every reason is disabled
      queue_request(bps_pkg::REQ_CYCLE, 8'hFF, 1'b1, 1'b1);
      queue_request(bps_pkg::REQ_EVENT, 8'hFF, 1'b0, 1'b0);   // event outside the off states
      queue_request(bps_pkg::REQ_DOWN,  8'h00, 1'b1, 1'b1);   // power-down while not on
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);   // init without rail: power-up
      // power-up runs out of retries and falls through to power-down
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      // off states following power-good both ways
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1);
      queue_request(bps_pkg::REQ_EVENT, 8'hFF, 1'b1, 1'b1);   // off but mask disabled

      drain();
      set_start_mask(8'hFF);
      @(posedge clock);
      queue_request(bps_pkg::REQ_EVENT, 8'h00, 1'b1, 1'b1);   // zero reason
      queue_request(bps_pkg::REQ_EVENT, 8'h80, 1'b0, 1'b1);   // accepted start, reason stored
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b0, 1'b1);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b1, 1'b1);   // rail present: on
      queue_request(bps_pkg::REQ_EVENT, 8'h01, 1'b1, 1'b1);   // event while on is ignored
      queue_request(bps_pkg::REQ_CYCLE, 8'h01, 1'b1, 1'b0);   // cycle from on replaces reason
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b1, 1'b0);   // reboot notice
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b1, 1'b0);
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b1, 1'b1);
      queue_request(bps_pkg::REQ_DOWN,  8'hFF, 1'b1, 1'b1);   // power-down honored when on
      queue_request(bps_pkg::REQ_TICK,  8'h00, 1'b1, 1'b0);   // rails off, reason cleared

      drain();
      set_start_mask(8'h5A);
      @(posedge clock);
      queue_request(bps_pkg::REQ_EVENT, 8'hA5, 1'b1, 1'b1);   // no overlap with the mask
      queue_request(bps_pkg::REQ_CYCLE, 8'h02, 1'b1, 1'b1);   // cycle taken from an off state

      // random phases across idling patterns and mask settings
      run_phase(0, 0, 8'hFF, 80, 1'b0);
      run_phase(66, 0, 8'h80, 70, 1'b0);
      run_phase(0, 66, 8'h01, 70, 1'b0);
      run_phase(30, 30, 8'($urandom_range(255)), 70, 1'b0);
      // receiver holds off while the sender keeps offering: input stalls
      run_phase(0, 0, 8'h00, 40, 1'b1);
      run_phase(30, 30, 8'($urandom_range(255)), 50, 1'b0);

      drain();
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* board_power_sequencer_top.f */
+incdir+src
src/bps_pkg.sv
src/bps_csr.sv
src/bps_core.sv
src/board_power_sequencer_top.sv
src/bps_checker.sv
dv/tb_board_power_sequencer_top.sv
